FILE: design/ftnn_pkg.sv
// shared types, constants and the semitone ratio rom for the nearest-note block
package ftnn_pkg;

	localparam int unsigned FRAC_BITS   = 8;
	localparam int unsigned REF_W       = 19;
	localparam int unsigned FREQ_W      = 23;
	localparam int unsigned TBL_W       = 24;
	localparam int unsigned NOTE_W      = 7;
	localparam int unsigned RATIO_W     = 31;
	localparam int unsigned PROD_W      = REF_W + RATIO_W;
	localparam int unsigned RATIO_SHIFT = 30;
	localparam int unsigned OCT_BIAS    = 6;
	localparam int unsigned SEMI_W      = 4;
	localparam int unsigned OCT_W       = 4;
	localparam int unsigned SH_W        = 6;

	localparam logic [SEMI_W-1:0] SEMI_START = SEMI_W'(3);
	localparam logic [SEMI_W-1:0] SEMI_LAST  = SEMI_W'(11);
	localparam logic [SH_W-1:0]   SH_BASE    = SH_W'(RATIO_SHIFT + OCT_BIAS);

	localparam logic [REF_W-1:0]  REF_LO      = REF_W'(10 << FRAC_BITS);
	localparam logic [REF_W-1:0]  REF_HI      = REF_W'(2000 << FRAC_BITS);
	localparam logic [REF_W-1:0]  REF_DEFAULT = REF_W'(440 << FRAC_BITS);
	localparam logic [FREQ_W-1:0] BAND_LO     = FREQ_W'(20 << FRAC_BITS);
	localparam logic [FREQ_W-1:0] BAND_HI     = FREQ_W'(20000 << FRAC_BITS);
	localparam logic [TBL_W-1:0]  TBL_MAX     = '1;

	typedef struct packed {
		logic build_start;
		logic build_step;
		logic load;
		logic rd_issue;
		logic cmp;
		logic out_load;
	} ftnn_cmd_t;

	typedef struct packed {
		logic build_last;
		logic search_done;
		logic in_band;
	} ftnn_sts_t;

	// 2^(k/12) in q30
	function automatic logic [RATIO_W-1:0] semitone_ratio(input logic [SEMI_W-1:0] k);
		logic [RATIO_W-1:0] r;
		unique case (k)
			4'd0:    r = 31'd1073741824;
			4'd1:    r = 31'd1137589835;
			4'd2:    r = 31'd1205234447;
			4'd3:    r = 31'd1276901417;
			4'd4:    r = 31'd1352829926;
			4'd5:    r = 31'd1433273380;
			4'd6:    r = 31'd1518500250;
			4'd7:    r = 31'd1608794974;
			4'd8:    r = 31'd1704458901;
			4'd9:    r = 31'd1805811301;
			4'd10:   r = 31'd1913190429;
			4'd11:   r = 31'd2026954652;
			default: r = '0;
		endcase
		return r;
	endfunction

endpackage

FILE: design/ftnn_ctrl.sv
// controller state machine: table build, binary search sequencing, output handshake
module ftnn_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic                 in_valid,
	input  logic                 out_stall,
	input  ftnn_pkg::ftnn_sts_t  sts,
	output logic                 in_stall,
	output logic                 out_valid,
	output ftnn_pkg::ftnn_cmd_t  cmd
);
	import ftnn_pkg::*;

	localparam logic [2:0] ST_BUILD = 3'd0;
	localparam logic [2:0] ST_DRAIN = 3'd1;
	localparam logic [2:0] ST_IDLE  = 3'd2;
	localparam logic [2:0] ST_READ  = 3'd3;
	localparam logic [2:0] ST_CMP   = 3'd4;
	localparam logic [2:0] ST_DONE  = 3'd5;

	logic [2:0] state_q;
	logic [2:0] state_nxt;
	logic       out_valid_q;
	logic       out_free;

	assign out_free  = !out_valid_q || !out_stall;
	assign in_stall  = (state_q != ST_IDLE) || cfg_we;
	assign out_valid = out_valid_q;

	always_comb begin
		cmd       = '0;
		state_nxt = state_q;
		unique case (state_q)
			ST_BUILD: begin
				cmd.build_step = 1'b1;
				if (sts.build_last) state_nxt = ST_DRAIN;
			end
			ST_DRAIN: begin
				state_nxt = ST_IDLE;
			end
			ST_IDLE: begin
				if (in_valid) begin
					cmd.load  = 1'b1;
					state_nxt = ST_READ;
				end
			end
			ST_READ: begin
				if (sts.search_done || !sts.in_band) begin
					state_nxt = ST_DONE;
				end else begin
					cmd.rd_issue = 1'b1;
					state_nxt    = ST_CMP;
				end
			end
			ST_CMP: begin
				cmd.cmp   = 1'b1;
				state_nxt = ST_READ;
			end
			ST_DONE: begin
				if (out_free) begin
					cmd.out_load = 1'b1;
					state_nxt    = ST_IDLE;
				end
			end
			default: begin
				state_nxt = ST_BUILD;
			end
		endcase
		// new reference restarts the table build
		if (cfg_we) begin
			cmd.build_start = 1'b1;
			cmd.build_step  = 1'b0;
			cmd.load        = 1'b0;
			state_nxt       = ST_BUILD;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_BUILD;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

FILE: design/ftnn_datapath.sv
// datapath: reference register, table build pipeline, note table memory, search and output registers
module ftnn_datapath #(
	parameter int NOTE_COUNT = 128
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [ftnn_pkg::REF_W-1:0]          a4_reference_q8,
	input  logic [ftnn_pkg::FREQ_W-1:0]         freq_q8,
	input  ftnn_pkg::ftnn_cmd_t                 cmd,
	output ftnn_pkg::ftnn_sts_t                 sts,
	output logic                                valid_res,
	output logic [ftnn_pkg::NOTE_W-1:0]         note_number,
	output logic [ftnn_pkg::TBL_W-1:0]          note_freq_q8
);
	import ftnn_pkg::*;

	localparam int AW = $clog2(NOTE_COUNT);
	localparam int IW = $clog2(NOTE_COUNT + 1);

	// reference and table build
	logic [REF_W-1:0]  ref_q;
	logic [REF_W-1:0]  eff_ref;
	logic [AW-1:0]     n_q;
	logic [SEMI_W-1:0] semi_q;
	logic [OCT_W-1:0]  oct_q;
	logic [PROD_W-1:0] prod_s1;
	logic [SH_W-1:0]   shift_s1;
	logic [AW-1:0]     addr_s1;
	logic              wr_s1;
	logic [PROD_W:0]   round_sum;
	logic [PROD_W:0]   round_shr;
	logic [TBL_W-1:0]  entry;
	logic [TBL_W-1:0]  tbl_mem [NOTE_COUNT];

	// search
	logic [FREQ_W-1:0] f_q;
	logic              in_band_q;
	logic [IW-1:0]     lo_q;
	logic [IW-1:0]     hi_q;
	logic              has_lo_q;
	logic              has_hi_q;
	logic [TBL_W-1:0]  lo_val_q;
	logic [TBL_W-1:0]  hi_val_q;
	logic [TBL_W-1:0]  rd_q;
	logic [IW:0]       mid_sum;
	logic [IW-1:0]     mid;
	logic [IW-1:0]     below;
	logic [TBL_W-1:0]  f_ext;
	logic [TBL_W-1:0]  d_lo;
	logic [TBL_W-1:0]  d_hi;
	logic              pick_hi;
	logic [AW-1:0]     pick_idx;
	logic [TBL_W-1:0]  pick_val;

	// output registers
	logic              valid_res_q;
	logic [NOTE_W-1:0] note_q;
	logic [TBL_W-1:0]  note_freq_q;

	assign eff_ref = (ref_q > REF_LO && ref_q < REF_HI) ? ref_q : REF_DEFAULT;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ref_q  <= REF_DEFAULT;
			n_q    <= '0;
			semi_q <= SEMI_START;
			oct_q  <= '0;
			wr_s1  <= 1'b0;
		end else begin
			if (cfg_we) ref_q <= a4_reference_q8;
			wr_s1 <= cmd.build_step && !cmd.build_start;
			if (cmd.build_start) begin
				n_q    <= '0;
				semi_q <= SEMI_START;
				oct_q  <= '0;
			end else if (cmd.build_step) begin
				n_q <= n_q + AW'(1);
				if (semi_q == SEMI_LAST) begin
					semi_q <= '0;
					oct_q  <= oct_q + OCT_W'(1);
				end else begin
					semi_q <= semi_q + SEMI_W'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.build_step) begin
			prod_s1  <= PROD_W'(eff_ref) * PROD_W'(semitone_ratio(semi_q));
			shift_s1 <= SH_BASE - SH_W'(oct_q);
			addr_s1  <= n_q;
		end
	end

	assign sts.build_last = (n_q == AW'(NOTE_COUNT - 1));

	// round half up, then saturate to the entry width
	assign round_sum = {1'b0, prod_s1} + ((PROD_W + 1)'(1) << (shift_s1 - SH_W'(1)));
	assign round_shr = round_sum >> shift_s1;
	assign entry     = (round_shr > (PROD_W + 1)'(TBL_MAX)) ? TBL_MAX : round_shr[TBL_W-1:0];

	always_ff @(posedge clk) begin
		if (wr_s1) tbl_mem[addr_s1] <= entry;
	end

	assign mid_sum = {1'b0, lo_q} + {1'b0, hi_q};
	assign mid     = mid_sum[IW:1];

	always_ff @(posedge clk) begin
		if (cmd.rd_issue) rd_q <= tbl_mem[mid[AW-1:0]];
	end

	assign f_ext = TBL_W'(f_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lo_q     <= '0;
			hi_q     <= '0;
			has_lo_q <= 1'b0;
			has_hi_q <= 1'b0;
		end else if (cmd.load) begin
			lo_q     <= '0;
			hi_q     <= IW'(NOTE_COUNT);
			has_lo_q <= 1'b0;
			has_hi_q <= 1'b0;
		end else if (cmd.cmp) begin
			if (rd_q < f_ext) begin
				lo_q     <= mid + IW'(1);
				has_lo_q <= 1'b1;
			end else begin
				hi_q     <= mid;
				has_hi_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			f_q       <= freq_q8;
			in_band_q <= (freq_q8 >= BAND_LO) && (freq_q8 <= BAND_HI);
		end
		if (cmd.cmp) begin
			if (rd_q < f_ext) begin
				lo_val_q <= rd_q;
			end else begin
				hi_val_q <= rd_q;
			end
		end
	end

	assign sts.search_done = (lo_q == hi_q);
	assign sts.in_band     = in_band_q;

	// lo_q is the first entry not below the input; lo_q - 1 the last one below
	assign d_lo     = f_ext - lo_val_q;
	assign d_hi     = hi_val_q - f_ext;
	assign below    = lo_q - IW'(1);
	assign pick_hi  = !has_lo_q || (has_hi_q && (d_hi < d_lo));
	assign pick_idx = pick_hi ? lo_q[AW-1:0] : below[AW-1:0];
	assign pick_val = pick_hi ? hi_val_q : lo_val_q;

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			valid_res_q <= in_band_q;
			note_q      <= in_band_q ? NOTE_W'(pick_idx) : '0;
			note_freq_q <= in_band_q ? pick_val : '0;
		end
	end

	assign valid_res    = valid_res_q;
	assign note_number  = note_q;
	assign note_freq_q8 = note_freq_q;

endmodule

FILE: design/frequency_to_nearest_note.sv
// top level of the nearest equal-tempered note finder
//
// input channel: in_valid / in_stall with freq_q8 (1/256 Hz). one word is taken at
// a time; in_stall stays high while a word is in flight or the note table is built.
// output channel: out_valid / out_stall with valid_res, note_number, note_freq_q8.
// an output register holds the result, so a new input word may be taken while the
// previous result is still stalled; that word then waits until the register frees.
// a4_reference_q8 is written when cfg_we is high; the write restarts the table build.
// table build: after reset and after each reference write, one entry per cycle
// through a 19x31 multiplier and a rounding stage; no input is taken meanwhile.
// search: an in-band word takes at most ceil(log2(NOTE_COUNT + 1)) binary search
// steps over the table memory, each a read state then a compare state; an
// out-of-band word skips the search. the memory read port, registered and shared
// by all steps, sets the step time.
// input pacing: a new word can be taken in the cycle in which out_valid rises;
// words are taken one at a time, each only after the last one has left the search.
// after reset out_valid is low and the table is built from the 440 Hz default.
module frequency_to_nearest_note #(
	parameter int NOTE_COUNT = 128
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [ftnn_pkg::REF_W-1:0]    a4_reference_q8,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [ftnn_pkg::FREQ_W-1:0]   freq_q8,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic                          valid_res,
	output logic [ftnn_pkg::NOTE_W-1:0]   note_number,
	output logic [ftnn_pkg::TBL_W-1:0]    note_freq_q8
);
	import ftnn_pkg::*;

	ftnn_cmd_t cmd;
	ftnn_sts_t sts;

	ftnn_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.in_valid  (in_valid),
		.out_stall (out_stall),
		.sts       (sts),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.cmd       (cmd)
	);

	ftnn_datapath #(
		.NOTE_COUNT (NOTE_COUNT)
	) u_datapath (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_we          (cfg_we),
		.a4_reference_q8 (a4_reference_q8),
		.freq_q8         (freq_q8),
		.cmd             (cmd),
		.sts             (sts),
		.valid_res       (valid_res),
		.note_number     (note_number),
		.note_freq_q8    (note_freq_q8)
	);

endmodule

FILE: design/ftnn_checker.sv
// port-level checker for the nearest-note block and its bind
module ftnn_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          cfg_we,
	input logic                          in_valid,
	input logic                          in_stall,
	input logic                          out_valid,
	input logic                          out_stall,
	input logic                          valid_res,
	input logic [ftnn_pkg::NOTE_W-1:0]   note_number,
	input logic [ftnn_pkg::TBL_W-1:0]    note_freq_q8
);
	import ftnn_pkg::*;

	a_invalid_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !valid_res |-> note_number == '0 && note_freq_q8 == '0)
		else $error("out-of-band word carries a nonzero note");

	a_valid_freq: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && valid_res |-> note_freq_q8 != '0)
		else $error("in-band word carries a zero note frequency");

	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("second input word taken while one is in flight");

	a_cfg_rebuild: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_we |=> in_stall)
		else $error("input taken right after a reference write");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(valid_res)
			&& $stable(note_number) && $stable(note_freq_q8))
		else $error("stalled output word changed");

endmodule

bind frequency_to_nearest_note ftnn_checker u_ftnn_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.cfg_we       (cfg_we),
	.in_valid     (in_valid),
	.in_stall     (in_stall),
	.out_valid    (out_valid),
	.out_stall    (out_stall),
	.valid_res    (valid_res),
	.note_number  (note_number),
	.note_freq_q8 (note_freq_q8)
);
